/* sv/pwmt_pkg.sv */
// Shared types and constants of the four-channel PWM timer.
package pwmt_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE   = 3'd0,
        CFG_RELOAD     = 3'd1,
        CFG_CH_ENABLE  = 3'd2,
        CFG_MOE        = 3'd3,
        CFG_PRELOAD_ON = 3'd4
    } t_cfg_idx;

    // Input operation codes.
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_DUTY = 1'b1
    } t_op;

    // Register reset values.
    localparam logic [15:0] PRESCALE_RST   = 16'd3;
    localparam logic [15:0] RELOAD_RST     = 16'hC350;
    localparam logic [3:0]  CH_ENABLE_RST  = 4'hF;
    localparam logic        MOE_RST        = 1'b1;
    localparam logic        PRELOAD_ON_RST = 1'b1;

    // Duty scaling: percent * reload fits in 23 bits, and the division by 100
    // is a multiply by ceil(2^30 / 100) followed by a shift, exact below 2^23.
    localparam logic [7:0]  DUTY_FULL   = 8'd100;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned PROD_W      = 23;
    localparam int unsigned RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned QUOT_FULL_W = PROD_W + RECIP_W;

endpackage

/* sv/four_channel_pwm_timer.sv */
// Four-channel edge-aligned PWM timer with prescaler, reload and preloaded compares.
//
//  Channel   Handshake                    Payload
//  input     i_in_valid / o_in_ready      i_operation, i_channel, i_duty_percent
//  output    o_out_valid / i_out_ready    o_pwm_out, o_counter_value, o_update_event
//  config    i_cfg_we (no wait)           i_cfg_index, i_cfg_wdata
//
// One beat is taken every cycle while o_in_ready is high. A beat is held in the
// input stage, where the percent-times-reload product is registered, and its
// result then passes on to the output register; the reciprocal multiply that
// divides by 100 sets the length of the second stage. Reset is synchronous and
// clears the counters, compares and handshake state. A stalled output holds its
// beat and backs up the input stage, after which o_in_ready drops.
module four_channel_pwm_timer #(
    parameter int CHANNELS      = 4,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [1:0]  i_channel,
    input  logic [7:0]  i_duty_percent,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_pwm_out,
    output logic [15:0] o_counter_value,
    output logic        o_update_event,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    localparam logic [15:0] RELOAD_MASK = (COUNTER_WIDTH >= 16) ? 16'hFFFF :
        16'((32'd1 << COUNTER_WIDTH) - 32'd1);

    // Configuration registers.
    logic [15:0] r_prescale_div;
    logic [15:0] r_reload;
    logic [3:0]  r_ch_enable;
    logic        r_moe;
    logic        r_preload_on;

    // Timer state.
    logic [15:0]              r_presc_cnt, n_presc_cnt;
    logic [COUNTER_WIDTH-1:0] r_counter, n_counter;
    logic [COUNTER_WIDTH-1:0] r_cmp_pre [CHANNELS];
    logic [COUNTER_WIDTH-1:0] n_cmp_pre [CHANNELS];
    logic [COUNTER_WIDTH-1:0] r_cmp_act [CHANNELS];
    logic [COUNTER_WIDTH-1:0] n_cmp_act [CHANNELS];
    logic                     r_running, n_running;
    logic                     n_update;

    // Input stage.
    logic                        r_s1_valid;
    pwmt_pkg::t_op               r_s1_op;
    logic [1:0]                  r_s1_chan;
    logic [pwmt_pkg::PROD_W-1:0] r_s1_prod;

    // Output register.
    logic        r_out_valid;
    logic [3:0]  r_out_pwm, n_out_pwm;
    logic [15:0] r_out_cnt;
    logic        r_out_update;

    logic                             w_out_free;
    logic                             w_s1_fire;
    logic                             w_in_fire;
    logic [15:0]                      w_reload_top;
    logic [COUNTER_WIDTH-1:0]         w_top;
    logic [pwmt_pkg::PCT_W-1:0]       w_pct;
    logic [pwmt_pkg::PROD_W-1:0]      w_prod;
    logic [pwmt_pkg::QUOT_FULL_W-1:0] w_quot_full;
    logic [15:0]                      w_duty_val16;
    logic [COUNTER_WIDTH-1:0]         w_duty_val;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_s1_fire   = r_s1_valid && w_out_free;
    assign o_in_ready  = !r_s1_valid || w_s1_fire;
    assign w_in_fire   = i_in_valid && o_in_ready;

    assign o_out_valid     = r_out_valid;
    assign o_pwm_out       = r_out_pwm;
    assign o_counter_value = r_out_cnt;
    assign o_update_event  = r_out_update;

    assign w_reload_top = r_reload & RELOAD_MASK;
    assign w_top        = COUNTER_WIDTH'(w_reload_top);

    // Saturated percent times reload, registered with the beat.
    assign w_pct  = (i_duty_percent > pwmt_pkg::DUTY_FULL) ?
                    pwmt_pkg::PCT_W'(pwmt_pkg::DUTY_FULL) : i_duty_percent[6:0];
    assign w_prod = pwmt_pkg::PROD_W'(w_pct) * pwmt_pkg::PROD_W'(w_reload_top);

    // Division by 100 of the registered product.
    assign w_quot_full  = pwmt_pkg::QUOT_FULL_W'(r_s1_prod) *
                          pwmt_pkg::QUOT_FULL_W'(pwmt_pkg::RECIP_100);
    assign w_duty_val16 = w_quot_full[pwmt_pkg::RECIP_SHIFT +: 16];
    assign w_duty_val   = COUNTER_WIDTH'(w_duty_val16);

    always_comb begin
        n_presc_cnt = r_presc_cnt;
        n_counter   = r_counter;
        n_running   = r_running;
        n_update    = 1'b0;
        n_cmp_pre   = r_cmp_pre;
        n_cmp_act   = r_cmp_act;
        if (r_s1_op == pwmt_pkg::OP_TICK) begin
            if (r_running) begin
                if (r_presc_cnt >= r_prescale_div) begin
                    n_presc_cnt = '0;
                    // A counter above a lowered reload wraps as well.
                    if (r_counter >= w_top) begin
                        n_counter = '0;
                        n_update  = 1'b1;
                        n_cmp_act = r_cmp_pre;
                    end else begin
                        n_counter = r_counter + COUNTER_WIDTH'(1);
                    end
                end else begin
                    n_presc_cnt = r_presc_cnt + 16'd1;
                end
            end
        end else begin
            n_running = 1'b1;
            for (int k = 0; k < CHANNELS; k++) begin
                if (int'(r_s1_chan) == k) begin
                    n_cmp_pre[k] = w_duty_val;
                    if (!r_preload_on) begin
                        n_cmp_act[k] = w_duty_val;
                    end
                end
            end
        end
    end

    // Only the first four channels reach the output port.
    for (genvar g = 0; g < 4; g++) begin : g_pwm
        if (g < CHANNELS) begin : g_on
            assign n_out_pwm[g] = n_running && r_moe && r_ch_enable[g] &&
                                  (n_counter < n_cmp_act[g]);
        end else begin : g_off
            assign n_out_pwm[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale_div <= pwmt_pkg::PRESCALE_RST;
            r_reload       <= pwmt_pkg::RELOAD_RST;
            r_ch_enable    <= pwmt_pkg::CH_ENABLE_RST;
            r_moe          <= pwmt_pkg::MOE_RST;
            r_preload_on   <= pwmt_pkg::PRELOAD_ON_RST;
        end else if (i_cfg_we) begin
            case (pwmt_pkg::t_cfg_idx'(i_cfg_index))
                pwmt_pkg::CFG_PRESCALE:   r_prescale_div <= i_cfg_wdata;
                pwmt_pkg::CFG_RELOAD:     r_reload       <= i_cfg_wdata;
                pwmt_pkg::CFG_CH_ENABLE:  r_ch_enable    <= i_cfg_wdata[3:0];
                pwmt_pkg::CFG_MOE:        r_moe          <= i_cfg_wdata[0];
                pwmt_pkg::CFG_PRELOAD_ON: r_preload_on   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc_cnt <= '0;
            r_counter   <= '0;
            r_running   <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_cmp_pre[k] <= '0;
                r_cmp_act[k] <= '0;
            end
        end else if (w_s1_fire) begin
            r_presc_cnt <= n_presc_cnt;
            r_counter   <= n_counter;
            r_running   <= n_running;
            r_cmp_pre   <= n_cmp_pre;
            r_cmp_act   <= n_cmp_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_op   <= pwmt_pkg::t_op'(i_operation);
            r_s1_chan <= i_channel;
            r_s1_prod <= w_prod;
        end
        if (w_s1_fire) begin
            r_out_pwm    <= n_out_pwm;
            r_out_cnt    <= 16'(n_counter);
            r_out_update <= n_update;
        end
    end

endmodule

/* sv/pwmt_checker.sv */
// Port-level checks for the PWM timer, bound to its top level.
module pwmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_pwm_out,
    input logic [15:0] o_counter_value,
    input logic        o_update_event
);

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pwm_out) && $stable(o_counter_value) &&
            $stable(o_update_event))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // With the output register empty the input side never stalls.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register is empty");

    // An update event always leaves the counter at zero.
    a_update_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_update_event |-> o_counter_value == 16'd0)
        else $error("update event with nonzero counter");

endmodule

bind four_channel_pwm_timer pwmt_checker u_pwmt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_pwm_out       (o_pwm_out),
    .o_counter_value (o_counter_value),
    .o_update_event  (o_update_event)
);
